>>> rtl/pwe_pkg.sv
// shared types and constants for the perfect-reflector white estimate block
`timescale 1ns / 1ps
package pwe_pkg;

    localparam int BIN_COUNT          = 767;
    localparam int TOP_BIN            = 766;
    localparam int BIN_W              = 10;
    localparam int MAX_PIXELS_LOG_DEF = 22;
    localparam int QUEUE_DEPTH_DEF    = 4;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } pwe_pixel_t;

    typedef struct packed {
        logic [7:0]       avg_blue;
        logic [7:0]       avg_green;
        logic [7:0]       avg_red;
        logic [7:0]       peak_level;
        logic [BIN_W-1:0] bright_threshold;
        logic [22:0]      bright_count;
        logic             none_bright;
    } pwe_result_t;

    // classified pixel handed from front to back
    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic             keep;
        logic             last;
    } pwe_entry_t;

endpackage

>>> rtl/pwe_front.sv
// front part: bins each pixel and flags pixels past the frame cap so the back does not count them
`timescale 1ns / 1ps
module pwe_front import pwe_pkg::*; #(
    parameter int MAX_PIXELS_LOG = MAX_PIXELS_LOG_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pwe_pixel_t s_data,
    output logic       q_valid,
    input  logic       q_ready,
    output pwe_entry_t q_data
);
    localparam int CW = MAX_PIXELS_LOG + 1;

    logic [CW-1:0] count_reg, count_next;
    logic          keep;

    // cap reached once the top bit is set
    assign keep    = !count_reg[MAX_PIXELS_LOG];
    assign s_ready = q_ready;
    assign q_valid = s_valid;

    always_comb begin
        q_data.bin   = BIN_W'(s_data.blue) + BIN_W'(s_data.green) + BIN_W'(s_data.red);
        q_data.blue  = s_data.blue;
        q_data.green = s_data.green;
        q_data.red   = s_data.red;
        q_data.keep  = keep;
        q_data.last  = s_data.frame_end;
        count_next   = count_reg;
        if (s_valid && q_ready) begin
            if (s_data.frame_end) begin
                count_next = '0;
            end else if (keep) begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end
endmodule

>>> rtl/pwe_fifo.sv
// short request queue between front and back
`timescale 1ns / 1ps
module pwe_fifo import pwe_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  pwe_entry_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pwe_entry_t out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    pwe_entry_t    slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] fill_reg;
    logic          push, pop;

    assign in_ready  = (fill_reg != NW'(DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_data  = slots[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + NW'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end
endmodule

>>> rtl/pwe_div.sv
// restoring divider, one quotient bit per cycle, 8-bit quotient
`timescale 1ns / 1ps
module pwe_div #(
    parameter int SW = 30,
    parameter int CW = 23
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [SW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [7:0]    quot
);
    logic          busy_reg, done_reg;
    logic [2:0]    step_reg;
    logic [SW-1:0] rem_reg, dvs_reg;
    logic [7:0]    q_reg;

    assign done = done_reg;
    assign quot = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dvs_reg <= SW'({divisor, 7'b0});
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (rem_reg >= dvs_reg) begin
                rem_reg <= rem_reg - dvs_reg;
                q_reg   <= {q_reg[6:0], 1'b1};
            end else begin
                q_reg   <= {q_reg[6:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
        end
    end
endmodule

>>> rtl/pwe_back.sv
// back part: bin memory updates, end-of-frame scan with clear, averages
`timescale 1ns / 1ps
module pwe_back import pwe_pkg::*; #(
    parameter int MAX_PIXELS_LOG = MAX_PIXELS_LOG_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  pwe_entry_t  q_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pwe_result_t m_data
);
    localparam int CW = MAX_PIXELS_LOG + 1;
    localparam int SW = MAX_PIXELS_LOG + 8;

    typedef struct packed {
        logic [CW-1:0] cnt;
        logic [SW-1:0] b;
        logic [SW-1:0] g;
        logic [SW-1:0] r;
    } bin_word_t;

    typedef enum logic [2:0] {
        S_CLR, S_PIX, S_UPD, S_SCAN, S_DIVST, S_DIV, S_OUT
    } state_t;

    bin_word_t        mem [BIN_COUNT];
    bin_word_t        rd_reg, wdata;
    logic             mem_we, mem_re;
    logic [BIN_W-1:0] mem_addr;

    state_t           state_reg;
    logic [BIN_W-1:0] addr_reg, pa_reg, thr_reg;
    logic             issue_reg, pv_reg, found_reg;
    pwe_entry_t       ent_reg;
    logic [CW-1:0]    tot_reg, run_reg, cnt_reg, run_next;
    logic [SW-1:0]    sb_reg, sg_reg, sr_reg;
    logic [7:0]       peak_reg, pix_max;
    logic [CW+3:0]    run_x10;
    logic             m_valid_reg;
    pwe_result_t      m_data_reg;
    logic             div_start;
    logic [2:0]       div_done;
    logic [7:0]       q_b, q_g, q_r;

    assign q_ready   = (state_reg == S_PIX);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign div_start = (state_reg == S_DIVST);

    assign run_next = run_reg + rd_reg.cnt;
    assign run_x10  = {1'b0, run_next, 3'b0} + {3'b0, run_next, 1'b0};

    always_comb begin
        pix_max = peak_reg;
        if (ent_reg.blue > pix_max) pix_max = ent_reg.blue;
        if (ent_reg.green > pix_max) pix_max = ent_reg.green;
        if (ent_reg.red > pix_max) pix_max = ent_reg.red;
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = addr_reg;
        wdata    = '0;
        unique case (state_reg)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_PIX: begin
                mem_re   = q_valid;
                mem_addr = q_data.bin;
            end
            S_UPD: begin
                mem_we    = ent_reg.keep;
                mem_addr  = ent_reg.bin;
                wdata.cnt = rd_reg.cnt + CW'(1);
                wdata.b   = rd_reg.b + SW'(ent_reg.blue);
                wdata.g   = rd_reg.g + SW'(ent_reg.green);
                wdata.r   = rd_reg.r + SW'(ent_reg.red);
            end
            S_SCAN: begin
                // read each bin once and clear it behind the read
                mem_re = issue_reg;
                mem_we = issue_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            addr_reg    <= BIN_W'(TOP_BIN);
            issue_reg   <= 1'b0;
            pv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            tot_reg     <= '0;
            run_reg     <= '0;
            cnt_reg     <= '0;
            sb_reg      <= '0;
            sg_reg      <= '0;
            sr_reg      <= '0;
            peak_reg    <= '0;
            thr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the output state sets valid itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR: begin
                    addr_reg <= addr_reg - BIN_W'(1);
                    if (addr_reg == '0) begin
                        state_reg <= S_PIX;
                    end
                end
                S_PIX: begin
                    if (q_valid) begin
                        ent_reg   <= q_data;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (ent_reg.keep) begin
                        tot_reg  <= tot_reg + CW'(1);
                        peak_reg <= pix_max;
                    end
                    if (ent_reg.last) begin
                        addr_reg  <= BIN_W'(TOP_BIN);
                        issue_reg <= 1'b1;
                        pv_reg    <= 1'b0;
                        state_reg <= S_SCAN;
                    end else begin
                        state_reg <= S_PIX;
                    end
                end
                S_SCAN: begin
                    pv_reg <= issue_reg;
                    pa_reg <= addr_reg;
                    if (issue_reg) begin
                        addr_reg <= addr_reg - BIN_W'(1);
                        if (addr_reg == '0) begin
                            issue_reg <= 1'b0;
                        end
                    end
                    if (pv_reg) begin
                        // bins above the threshold are those seen before it
                        if (!found_reg) begin
                            if (run_x10 > {4'b0, tot_reg}) begin
                                found_reg <= 1'b1;
                                thr_reg   <= pa_reg;
                            end else begin
                                run_reg <= run_next;
                                cnt_reg <= cnt_reg + rd_reg.cnt;
                                sb_reg  <= sb_reg + rd_reg.b;
                                sg_reg  <= sg_reg + rd_reg.g;
                                sr_reg  <= sr_reg + rd_reg.r;
                            end
                        end
                        if (pa_reg == '0) begin
                            state_reg <= S_DIVST;
                        end
                    end
                end
                S_DIVST: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (&div_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                 <= 1'b1;
                        m_data_reg.none_bright      <= (cnt_reg == '0);
                        m_data_reg.avg_blue         <= (cnt_reg == '0) ? 8'd0 : q_b;
                        m_data_reg.avg_green        <= (cnt_reg == '0) ? 8'd0 : q_g;
                        m_data_reg.avg_red          <= (cnt_reg == '0) ? 8'd0 : q_r;
                        m_data_reg.peak_level       <= peak_reg;
                        m_data_reg.bright_threshold <= thr_reg;
                        m_data_reg.bright_count     <= 23'(cnt_reg);
                        tot_reg   <= '0;
                        run_reg   <= '0;
                        cnt_reg   <= '0;
                        sb_reg    <= '0;
                        sg_reg    <= '0;
                        sr_reg    <= '0;
                        peak_reg  <= '0;
                        thr_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_PIX;
                    end
                end
                default: begin
                    state_reg <= S_CLR;
                end
            endcase
        end
    end

    pwe_div #(.SW(SW), .CW(CW)) u_div_b (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(sb_reg), .divisor(cnt_reg), .done(div_done[0]), .quot(q_b)
    );
    pwe_div #(.SW(SW), .CW(CW)) u_div_g (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(sg_reg), .divisor(cnt_reg), .done(div_done[1]), .quot(q_g)
    );
    pwe_div #(.SW(SW), .CW(CW)) u_div_r (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(sr_reg), .divisor(cnt_reg), .done(div_done[2]), .quot(q_r)
    );
endmodule

>>> rtl/perfect_reflector_white_estimate_unit.sv
// top level of the perfect-reflector white estimate block
//
//  channel  | direction | ports                      | moves
//  s_       | in        | s_valid s_ready s_data     | one pixel request
//  m_       | out       | m_valid m_ready m_data     | one frame estimate
//
// the front takes one pixel per cycle into a 4-entry queue while it has room; the back
// does a read-modify-write of the single-port bin memory per pixel (S_PIX, S_UPD)
// at the frame end the back scans all 767 bins (one per cycle, clearing each),
// then runs the three channel dividers to form the averages
// after reset a clearing pass over all 767 bins runs before pixels leave the queue
// a waiting result does not block the next frame's pixels
`timescale 1ns / 1ps
module perfect_reflector_white_estimate_unit import pwe_pkg::*; #(
    parameter int MAX_PIXELS_LOG = MAX_PIXELS_LOG_DEF,
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pwe_pixel_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pwe_result_t m_data
);
    logic       fq_valid, fq_ready, bq_valid, bq_ready;
    pwe_entry_t fq_data, bq_data;

    pwe_front #(.MAX_PIXELS_LOG(MAX_PIXELS_LOG)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    pwe_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
        .out_valid(bq_valid), .out_ready(bq_ready), .out_data(bq_data)
    );

    pwe_back #(.MAX_PIXELS_LOG(MAX_PIXELS_LOG)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

>>> rtl/pwe_checker.sv
// port-level checks for the white estimate block, bound to the top level
`timescale 1ns / 1ps
module pwe_checker import pwe_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input pwe_pixel_t  s_data,
    input logic        m_valid,
    input logic        m_ready,
    input pwe_result_t m_data
);
    // a waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.none_bright |->
            m_data.avg_blue == 8'd0 && m_data.avg_green == 8'd0 && m_data.avg_red == 8'd0)
        else $error("averages not zero with no bright pixel");

    // a mean cannot exceed the largest channel value
    a_avg_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.avg_blue <= m_data.peak_level
            && m_data.avg_green <= m_data.peak_level
            && m_data.avg_red <= m_data.peak_level)
        else $error("average above peak");

    a_thr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.bright_threshold <= BIN_W'(TOP_BIN))
        else $error("threshold out of range");
endmodule

bind perfect_reflector_white_estimate_unit pwe_checker u_pwe_checker (.*);

>>> tb/tb_top.sv
// self-checking testbench for the perfect-reflector white estimate block
`timescale 1ns / 1ps
module tb_top;
    import pwe_pkg::*;

    localparam int HOLD_CYCLES = 4000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pwe_pixel_t  s_data;
    logic        m_valid;
    logic        m_ready;
    pwe_result_t m_data;

    perfect_reflector_white_estimate_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    pwe_pixel_t  pixel_queue[$];
    pwe_result_t estimate_queue[$];

    longint unsigned hist_count[BIN_COUNT];
    longint unsigned hist_blue[BIN_COUNT];
    longint unsigned hist_green[BIN_COUNT];
    longint unsigned hist_red[BIN_COUNT];
    longint unsigned seen_pixels;
    logic [7:0]      seen_peak;

    int mismatches = 0;
    int pixels_taken = 0;
    int frames_checked = 0;
    int bright_frames = 0;
    int idle_phase = 0;
    int hold_left = 0;
    bit hold_done = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_hist();
        for (int i = 0; i < BIN_COUNT; i++) begin
            hist_count[i] = 0;
            hist_blue[i] = 0;
            hist_green[i] = 0;
            hist_red[i] = 0;
        end
        seen_pixels = 0;
        seen_peak = 0;
    endfunction

    // fold one pixel into the histogram, close the frame on its last pixel
    function automatic void absorb_pixel(pwe_pixel_t px);
        int bin;
        longint unsigned running, cnt, sb, sg, sr;
        int thr;
        pwe_result_t est;
        if (seen_pixels < (64'd1 << MAX_PIXELS_LOG_DEF)) begin
            bin = px.blue + px.green + px.red;
            if (px.blue > seen_peak) seen_peak = px.blue;
            if (px.green > seen_peak) seen_peak = px.green;
            if (px.red > seen_peak) seen_peak = px.red;
            hist_count[bin] += 1;
            hist_blue[bin] += px.blue;
            hist_green[bin] += px.green;
            hist_red[bin] += px.red;
            seen_pixels += 1;
        end
        if (!px.frame_end) return;
        thr = 0;
        running = 0;
        for (int i = TOP_BIN; i >= 0; i--) begin
            running += hist_count[i];
            if (running * 10 > seen_pixels) begin
                thr = i;
                break;
            end
        end
        cnt = 0; sb = 0; sg = 0; sr = 0;
        for (int k = thr + 1; k < BIN_COUNT; k++) begin
            cnt += hist_count[k];
            sb += hist_blue[k];
            sg += hist_green[k];
            sr += hist_red[k];
        end
        est = '0;
        if (cnt != 0) begin
            est.avg_blue = 8'(sb / cnt);
            est.avg_green = 8'(sg / cnt);
            est.avg_red = 8'(sr / cnt);
        end
        est.none_bright = (cnt == 0);
        est.peak_level = seen_peak;
        est.bright_threshold = BIN_W'(thr);
        est.bright_count = 23'(cnt);
        estimate_queue.insert(estimate_queue.size(), est);
        clear_hist();
    endfunction

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch frame %0d %s: got %0d expected %0d",
                 frames_checked, what, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(200, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_frame(int n, int style);
        pwe_pixel_t px;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: begin px.blue = 0; px.green = 0; px.red = 0; end
                1: begin px.blue = 255; px.green = 255; px.red = 255; end
                2: begin
                    // walking ones plus the extremes
                    px.blue = 8'(1 << (i % 8));
                    px.green = (i % 3 == 0) ? 8'd255 : 8'(1 << ((i + 3) % 8));
                    px.red = (i % 4 == 0) ? 8'd0 : ~px.blue;
                end
                default: begin
                    px.blue = pick_level();
                    px.green = pick_level();
                    px.red = pick_level();
                end
            endcase
            px.frame_end = (i == n - 1);
            pixel_queue.insert(pixel_queue.size(), px);
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_data <= '0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_pixel(s_data);
                pixels_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pixel_queue.size() > 0 &&
                    !(idle_phase == 0 && $urandom_range(0, 99) < 14) &&
                    !(idle_phase == 1 && $urandom_range(0, 99) < 60)) begin
                    s_valid <= 1;
                    s_data <= pixel_queue.pop_front();
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        pwe_result_t want;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (estimate_queue.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    want = estimate_queue.pop_front();
                    if (m_data.avg_blue != want.avg_blue)
                        report("avg_blue", m_data.avg_blue, want.avg_blue);
                    if (m_data.avg_green != want.avg_green)
                        report("avg_green", m_data.avg_green, want.avg_green);
                    if (m_data.avg_red != want.avg_red)
                        report("avg_red", m_data.avg_red, want.avg_red);
                    if (m_data.peak_level != want.peak_level)
                        report("peak_level", m_data.peak_level, want.peak_level);
                    if (m_data.bright_threshold != want.bright_threshold)
                        report("bright_threshold", m_data.bright_threshold,
                               want.bright_threshold);
                    if (m_data.bright_count != want.bright_count)
                        report("bright_count", m_data.bright_count, want.bright_count);
                    if (m_data.none_bright != want.none_bright)
                        report("none_bright", m_data.none_bright, want.none_bright);
                    if (!want.none_bright) bright_frames++;
                    frames_checked++;
                end
            end
            // long hold-off once so results pile up while pixels keep coming
            if (!hold_done && pixels_taken >= 150) begin
                hold_done <= 1;
                hold_left <= HOLD_CYCLES;
                m_ready <= 0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 0;
            end else if (idle_phase == 0) begin
                m_ready <= ($urandom_range(0, 99) >= 60);
            end else if (idle_phase == 1) begin
                m_ready <= ($urandom_range(0, 99) >= 14);
            end else begin
                m_ready <= 1;
            end
        end
    end

    initial begin
        int queued;
        int n;
        aresetn = 0;
        clear_hist();
        queue_frame(1, 1);
        queue_frame(1, 0);
        queue_frame(3, 0);
        queue_frame(12, 2);
        queue_frame(8, 3);
        queued = 25;
        while (queued < 1000) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
            queue_frame(n, ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : 3);
            queued += n;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        wait (pixels_taken >= queued / 3);
        idle_phase = 1;
        wait (pixels_taken >= 2 * queued / 3);
        idle_phase = 2;
        wait (pixels_taken == queued);
        wait (estimate_queue.size() == 0);
        repeat (1000) @(posedge aclk);
        if (estimate_queue.size() != 0) begin
            report("results never arrived", 0, estimate_queue.size());
        end
        $display("run covered %0d pixels in %0d frames, %0d with bright pixels",
                 pixels_taken, frames_checked, bright_frames);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("** perfect_reflector_white_estimate_unit: PASSED **");
        else
            $display("** perfect_reflector_white_estimate_unit: FAILED **");
        $finish;
    end

    initial begin
        #100ms;
        $display("timeout at %0t", $realtime);
        $display("** perfect_reflector_white_estimate_unit: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/pwe_pkg.sv
rtl/pwe_front.sv
rtl/pwe_fifo.sv
rtl/pwe_div.sv
rtl/pwe_back.sv
rtl/perfect_reflector_white_estimate_unit.sv
rtl/pwe_checker.sv
tb/tb_top.sv
